### rtl/dmhq_pkg.sv
// ----------------------------------------------------------------------------
// dmhq_pkg: shared types and constants of the deadline heap queue
// Request modes, status codes, payload structs of both channels, cell commands and FSM states.
// ----------------------------------------------------------------------------
package dmhq_pkg;

  localparam int DEF_CAPACITY = 256;

  localparam logic [1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [1:0] MODE_CANCEL   = 2'd1;
  localparam logic [1:0] MODE_PEEK     = 2'd2;
  localparam logic [1:0] MODE_TAKE     = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_SEQ_EXH   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD       = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_FAULT     = 3'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] deadline;
    logic [63:0] user_token;
    logic [8:0]  handle_slot_code;
    logic [15:0] handle_generation;
    logic [63:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [8:0]  result_slot_code;
    logic [15:0] result_generation;
    logic [63:0] result_deadline;
    logic [63:0] result_token;
    logic [8:0]  occupancy;
  } rsp_t;

  // Commands broadcast down the cell row
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_INSERT,
    CMD_REMOVE
  } cmd_e;

  // Control group from the top level to every cell
  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] key_deadline;
    logic [63:0] key_sequence;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ADDR,
    S_WORK,
    S_SHIFT,
    S_RESP
  } state_e;

endpackage

### rtl/dmhq_if.sv
// ----------------------------------------------------------------------------
// dmhq_stream_if: valid/ready channel
// Carries one payload of the given type with a source and a sink view.
// ----------------------------------------------------------------------------
`default_nettype none
interface dmhq_stream_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/dmhq_cell.sv
// ----------------------------------------------------------------------------
// dmhq_cell: one position of the sorted queue row
// Holds one entry keyed by deadline and sequence; shifts toward the tail on
// insert and toward the head on remove, one hop per cycle with its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module dmhq_cell
  import dmhq_pkg::*;
#(
  parameter int SW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cell_ctl_t       ctl,
  input  wire logic            shift_in_en,   // remove: take from tail neighbor
  input  wire logic            rm_here,       // remove starts at or before this cell
  input  wire logic            prev_valid,
  input  wire logic            prev_ahead,    // head neighbor is earlier than key
  input  wire logic [63:0]     prev_deadline,
  input  wire logic [63:0]     prev_sequence,
  input  wire logic [SW-1:0]   prev_slot,
  input  wire logic            nxt_valid,
  input  wire logic [63:0]     nxt_deadline,
  input  wire logic [63:0]     nxt_sequence,
  input  wire logic [SW-1:0]   nxt_slot,
  input  wire logic [SW-1:0]   new_slot,
  output logic                 valid,
  output logic                 ahead,         // this entry is earlier than key
  output logic [63:0]          deadline,
  output logic [63:0]          sequence_no,
  output logic [SW-1:0]        slot
);
  always_comb begin
    ahead = valid && ((deadline < ctl.key_deadline) ||
            ((deadline == ctl.key_deadline) && (sequence_no < ctl.key_sequence)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.cmd == CMD_INSERT) begin
      if (!ahead && prev_ahead) begin
        valid       <= 1'b1;
        deadline    <= ctl.key_deadline;
        sequence_no <= ctl.key_sequence;
        slot        <= new_slot;
      end else if (!ahead && !prev_ahead && valid) begin
        // shift toward the tail
        valid       <= prev_valid;
        deadline    <= prev_deadline;
        sequence_no <= prev_sequence;
        slot        <= prev_slot;
      end else if (!valid && !prev_ahead) begin
        valid       <= prev_valid;
        deadline    <= prev_deadline;
        sequence_no <= prev_sequence;
        slot        <= prev_slot;
      end
    end else if (ctl.cmd == CMD_REMOVE && rm_here && shift_in_en) begin
      valid       <= nxt_valid;
      deadline    <= nxt_deadline;
      sequence_no <= nxt_sequence;
      slot        <= nxt_slot;
    end
  end
endmodule
`default_nettype wire

### rtl/deadline_min_heap_queue_unit.sv
// ----------------------------------------------------------------------------
// deadline_min_heap_queue_unit: deadline timer queue
// One request at a time. After acceptance the unit reads the slot tables at
// the addressed slot (S_ADDR), forms the result (S_WORK) and lets the cell
// row shift (S_SHIFT); the response is then offered in S_RESP, and the next
// request is accepted in S_IDLE after the response is taken. All cells
// compare against the key in parallel, so latency does not grow with
// CAPACITY. After reset a clearing pass over every slot loads the free stack
// and the slot generations; requests are held off meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module deadline_min_heap_queue_unit
  import dmhq_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  dmhq_stream_if.sink   req,
  dmhq_stream_if.source rsp
);
  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_e state, state_next;
  req_t   r;
  rsp_t   res, res_next;

  logic [63:0] slot_deadline [CAPACITY];
  logic [63:0] slot_token    [CAPACITY];
  logic [15:0] slot_generation [CAPACITY];
  logic [CAPACITY-1:0] slot_active;
  logic [SW-1:0] free_stack [CAPACITY];
  logic [CW-1:0] free_top;
  logic [CW-1:0] queued_count;
  logic [63:0]   next_sequence;
  logic [SW-1:0] init_idx;
  logic          init_last;

  // Registered table reads
  logic [SW-1:0] fs_rd;
  logic [SW-1:0] sa;
  logic [SW-1:0] sa_q;
  logic [15:0]   gen_rd;
  logic [63:0]   dl_rd;
  logic [63:0]   tok_rd;
  logic          act_rd;

  cell_ctl_t ctl;
  logic [CAPACITY-1:0] c_valid, c_ahead, rm_mask;
  logic [63:0] c_dl [CAPACITY];
  logic [63:0] c_sq [CAPACITY];
  logic [SW-1:0] c_sl [CAPACITY];
  logic [SW-1:0] new_slot;
  logic [SW-1:0] rm_slot;
  logic          rm_go;
  logic          done;

  // Per-slot sequence numbers live in the cells; locate by slot match
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic pv, pb; logic [63:0] pd, ps; logic [SW-1:0] pl;
      logic nv; logic [63:0] nd, ns; logic [SW-1:0] nl;
      if (g == 0) begin : g_head
        assign pv = 1'b0; assign pb = 1'b1; assign pd = '0; assign ps = '0; assign pl = '0;
        assign rm_mask[0] = c_valid[0] && (c_sl[0] == rm_slot);
      end else begin : g_mid
        assign pv = c_valid[g-1]; assign pb = c_ahead[g-1];
        assign pd = c_dl[g-1]; assign ps = c_sq[g-1]; assign pl = c_sl[g-1];
        assign rm_mask[g] = rm_mask[g-1] || (c_valid[g] && (c_sl[g] == rm_slot));
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign nv = 1'b0; assign nd = '0; assign ns = '0; assign nl = '0;
      end else begin : g_body
        assign nv = c_valid[g+1]; assign nd = c_dl[g+1];
        assign ns = c_sq[g+1]; assign nl = c_sl[g+1];
      end
      dmhq_cell #(.SW(SW)) u_cell (
        .clk, .rst, .ctl,
        .shift_in_en(rm_go), .rm_here(rm_mask[g]),
        .prev_valid(pv), .prev_ahead(pb), .prev_deadline(pd),
        .prev_sequence(ps), .prev_slot(pl),
        .nxt_valid(nv), .nxt_deadline(nd), .nxt_sequence(ns), .nxt_slot(nl),
        .new_slot(new_slot),
        .valid(c_valid[g]), .ahead(c_ahead[g]), .deadline(c_dl[g]),
        .sequence_no(c_sq[g]), .slot(c_sl[g])
      );
    end
  endgenerate

  logic [SW-1:0] cs;
  logic [9:0]    code_m1;
  logic          hit;
  assign code_m1 = {1'b0, r.handle_slot_code} - 10'd1;
  assign cs = code_m1[SW-1:0];
  assign hit = (code_m1 < 10'(CAPACITY)) && act_rd && (gen_rd == r.handle_generation);
  assign new_slot = sa_q;
  assign rm_slot = sa_q;
  assign init_last = (init_idx == SW'(CAPACITY - 1));

  // Slot addressed by the held request
  always_comb begin
    case (r.mode)
      MODE_SCHEDULE: sa = fs_rd;
      MODE_CANCEL:   sa = cs;
      default:       sa = c_sl[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    req.ready  = (state == S_IDLE);
    rsp.valid  = (state == S_RESP);
    rsp.data   = res;
    ctl.cmd    = CMD_NOP;
    ctl.key_deadline = r.deadline;
    ctl.key_sequence = next_sequence;
    rm_go = 1'b0;
    done  = 1'b0;
    case (state)
      S_INIT:  if (init_last) state_next = S_IDLE;
      S_IDLE:  if (req.valid) state_next = S_ADDR;
      S_ADDR:  state_next = S_WORK;
      S_WORK:  state_next = S_SHIFT;
      S_SHIFT: begin
        done = 1'b1;
        state_next = S_RESP;
        if (res.status == ST_OK && r.mode == MODE_SCHEDULE) ctl.cmd = CMD_INSERT;
        if (res.status == ST_OK && (r.mode == MODE_CANCEL || r.mode == MODE_TAKE)) begin
          ctl.cmd = CMD_REMOVE; rm_go = 1'b1;
        end
      end
      S_RESP:  if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_next = '0;
    res_next.occupancy = 9'(queued_count);
    case (r.mode)
      MODE_SCHEDULE: begin
        if (free_top == '0) res_next.status = ST_FULL;
        else if (&next_sequence) res_next.status = ST_SEQ_EXH;
        else if (act_rd || gen_rd == 16'd0) res_next.status = ST_FAULT;
        else begin
          res_next.status = ST_OK;
          res_next.result_slot_code = 9'({1'b0, sa_q} + 1'b1);
          res_next.result_generation = gen_rd;
          res_next.occupancy = 9'(queued_count + 1'b1);
        end
      end
      MODE_CANCEL: begin
        if (r.handle_slot_code == 9'd0 || r.handle_generation == 16'd0)
          res_next.status = ST_BAD;
        else if (!hit) res_next.status = ST_NOT_FOUND;
        else begin
          res_next.status = ST_OK;
          res_next.result_slot_code = r.handle_slot_code;
          res_next.result_generation = r.handle_generation;
          res_next.result_deadline = dl_rd;
          res_next.result_token = tok_rd;
          res_next.occupancy = 9'(queued_count - 1'b1);
        end
      end
      default: begin
        if (queued_count == '0 ||
            (r.mode == MODE_TAKE && dl_rd > r.now_time))
          res_next.status = ST_EMPTY;
        else begin
          res_next.status = ST_OK;
          res_next.result_slot_code = 9'({1'b0, sa_q} + 1'b1);
          res_next.result_generation = gen_rd;
          res_next.result_deadline = dl_rd;
          res_next.result_token = tok_rd;
          if (r.mode == MODE_TAKE) res_next.occupancy = 9'(queued_count - 1'b1);
        end
      end
    endcase
  end

  // Slot tables and free stack
  always_ff @(posedge clk) begin
    fs_rd <= free_stack[free_top[SW-1:0] - 1'b1];
    if (state == S_ADDR) begin
      gen_rd <= slot_generation[sa];
      dl_rd  <= slot_deadline[sa];
      tok_rd <= slot_token[sa];
    end
    if (state == S_INIT) begin
      slot_generation[init_idx] <= 16'd1;
      free_stack[init_idx]      <= SW'(CAPACITY - 1) - init_idx;
    end
    if (done && res.status == ST_OK) begin
      if (r.mode == MODE_SCHEDULE) begin
        slot_deadline[sa_q] <= r.deadline;
        slot_token[sa_q]    <= r.user_token;
      end else if (r.mode != MODE_PEEK) begin
        // retire or recycle the slot
        if (&gen_rd) begin
          slot_generation[sa_q] <= 16'd0;
        end else begin
          slot_generation[sa_q] <= gen_rd + 16'd1;
          if (free_top < CW'(CAPACITY)) free_stack[free_top[SW-1:0]] <= sa_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active   <= '0;
      free_top      <= CW'(CAPACITY);
      queued_count  <= '0;
      next_sequence <= '0;
      init_idx      <= '0;
    end else begin
      if (state == S_INIT) init_idx <= init_idx + 1'b1;
      if (state == S_IDLE && req.valid) r <= req.data;
      if (state == S_ADDR) begin
        sa_q   <= sa;
        act_rd <= slot_active[sa];
      end
      if (state == S_WORK) begin
        res <= res_next;
        // a faulty popped slot stays consumed
        if (r.mode == MODE_SCHEDULE && res_next.status == ST_FAULT)
          free_top <= free_top - 1'b1;
      end
      if (done && res.status == ST_OK) begin
        if (r.mode == MODE_SCHEDULE) begin
          free_top <= free_top - 1'b1;
          queued_count <= queued_count + 1'b1;
          next_sequence <= next_sequence + 1'b1;
          slot_active[sa_q] <= 1'b1;
        end else if (r.mode != MODE_PEEK) begin
          queued_count <= queued_count - 1'b1;
          slot_active[sa_q] <= 1'b0;
          if (!(&gen_rd) && free_top < CW'(CAPACITY)) free_top <= free_top + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/dmhq_checker.sv
// ----------------------------------------------------------------------------
// dmhq_checker: port-level checks of the deadline queue
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module dmhq_checker
  import dmhq_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire rsp_t rsp_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped while stalled");
  a_one: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request taken while result pending");
  a_err: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.result_slot_code == 9'd0)
    else $error("error result carries a handle");
  a_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == ST_OK |-> rsp_data.result_slot_code != 9'd0)
    else $error("ok result without slot");
endmodule

bind deadline_min_heap_queue_unit dmhq_checker u_chk (
  .clk, .rst, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the deadline heap timer queue
// Drives schedule, cancel, peek and take-ready requests over the request
// channel and checks every response against a behavioral queue model that
// tracks slots, generations, the free stack and deadline/sequence ordering.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import dmhq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = DEF_CAPACITY;
  localparam int N_ITEMS = 1900;
  localparam logic [15:0] GEN_TOP = 16'hFFFF;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  dmhq_stream_if #(.T(req_t)) req (.clk(clk));
  dmhq_stream_if #(.T(rsp_t)) rsp (.clk(clk));

  deadline_min_heap_queue_unit #(.CAPACITY(NSLOT)) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Queue model state
  logic [63:0] m_deadline [NSLOT];
  logic [63:0] m_token [NSLOT];
  logic [63:0] m_seq [NSLOT];
  logic [15:0] m_gen [NSLOT];
  logic        m_active [NSLOT];
  logic [7:0]  m_free [NSLOT];
  int          m_free_cnt;
  int          m_queued;
  logic [63:0] m_next_seq;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   issued_cnt = 0;
  int   accepted_cnt = 0;
  int   gen_cnt = 0;
  int   idle_mode = 0;
  int   rx_hold = 0;
  int   mismatches = 0;
  int   rsp_cnt = 0;
  int   status_seen [8];
  int   peak_queued = 0;

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int s = 0; s < NSLOT; s++) begin
      if (m_active[s]) begin
        if (best < 0 || m_deadline[s] < m_deadline[best] ||
            (m_deadline[s] == m_deadline[best] && m_seq[s] < m_seq[best]))
          best = s;
      end
    end
    return best;
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < NSLOT; i++) begin
      m_deadline[i] = '0;
      m_token[i] = '0;
      m_seq[i] = '0;
      m_gen[i] = 16'd1;
      m_active[i] = 1'b0;
      m_free[i] = 8'(NSLOT - 1 - i);
    end
    m_free_cnt = NSLOT;
    m_queued = 0;
    m_next_seq = '0;
  endfunction

  // Remove slot s from the queue and report it as the event
  function automatic void remove_slot(int s, ref rsp_t r);
    r.result_slot_code = 9'(s + 1);
    r.result_generation = m_gen[s];
    r.result_deadline = m_deadline[s];
    r.result_token = m_token[s];
    m_queued--;
    m_deadline[s] = '0;
    m_token[s] = '0;
    m_seq[s] = '0;
    m_active[s] = 1'b0;
    if (m_gen[s] == GEN_TOP) begin
      m_gen[s] = '0;
    end else begin
      m_gen[s] = m_gen[s] + 16'd1;
      if (m_free_cnt < NSLOT) begin
        m_free[m_free_cnt] = 8'(s);
        m_free_cnt++;
      end
    end
  endfunction

  function automatic rsp_t queue_step(req_t q);
    rsp_t r;
    int s;
    r = '0;
    r.status = ST_OK;
    case (q.mode)
      MODE_SCHEDULE: begin
        if (m_free_cnt == 0) r.status = ST_FULL;
        else if (m_next_seq == '1) r.status = ST_SEQ_EXH;
        else begin
          m_free_cnt--;
          s = int'(m_free[m_free_cnt]);
          if (m_active[s] || m_gen[s] == 0) r.status = ST_FAULT;
          else begin
            m_queued++;
            m_deadline[s] = q.deadline;
            m_token[s] = q.user_token;
            m_seq[s] = m_next_seq;
            m_next_seq++;
            m_active[s] = 1'b1;
            r.result_slot_code = 9'(s + 1);
            r.result_generation = m_gen[s];
          end
        end
      end
      MODE_CANCEL: begin
        if (q.handle_slot_code == 0 || q.handle_generation == 0) r.status = ST_BAD;
        else begin
          s = int'(q.handle_slot_code) - 1;
          if (s >= NSLOT || !m_active[s] || m_gen[s] != q.handle_generation)
            r.status = ST_NOT_FOUND;
          else remove_slot(s, r);
        end
      end
      MODE_PEEK: begin
        s = earliest_slot();
        if (s < 0) r.status = ST_EMPTY;
        else begin
          r.result_slot_code = 9'(s + 1);
          r.result_generation = m_gen[s];
          r.result_deadline = m_deadline[s];
          r.result_token = m_token[s];
        end
      end
      default: begin
        s = earliest_slot();
        if (s < 0 || m_deadline[s] > q.now_time) r.status = ST_EMPTY;
        else remove_slot(s, r);
      end
    endcase
    r.occupancy = 9'(m_queued);
    return r;
  endfunction

  // Driver: offer requests at the falling edge
  always @(negedge clk) begin
    if (!rst && (!req.valid || issued_cnt == accepted_cnt)) begin
      if (pending_reqs.size() > 0 &&
          !(idle_mode == 0 && $urandom_range(0, 99) < 23) &&
          !(idle_mode == 1 && $urandom_range(0, 99) < 61)) begin
        req.data <= pending_reqs.pop_front();
        req.valid <= 1'b1;
        issued_cnt <= issued_cnt + 1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receiver: hold off for a counted stretch or stall at random
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rsp.ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      rsp.ready <= !((idle_mode == 0 && $urandom_range(0, 99) < 61) ||
                     (idle_mode == 1 && $urandom_range(0, 99) < 23));
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH response %0d %s: expected %0h got %0h", rsp_cnt, name, exp_v, act_v);
    end
  endtask

  // Monitor: predict on accepted requests, check accepted responses
  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && req.valid && req.ready) begin
      expected_rsps.push_back(queue_step(req.data));
      accepted_cnt <= accepted_cnt + 1;
      if (m_queued > peak_queued) peak_queued = m_queued;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH unexpected response %p", rsp.data);
      end else begin
        exp_r = expected_rsps.pop_front();
        check_field("status", 64'(exp_r.status), 64'(rsp.data.status));
        check_field("slot_code", 64'(exp_r.result_slot_code), 64'(rsp.data.result_slot_code));
        check_field("generation", 64'(exp_r.result_generation),
                    64'(rsp.data.result_generation));
        check_field("deadline", exp_r.result_deadline, rsp.data.result_deadline);
        check_field("token", exp_r.result_token, rsp.data.result_token);
        check_field("occupancy", 64'(exp_r.occupancy), 64'(rsp.data.occupancy));
        status_seen[exp_r.status]++;
      end
      rsp_cnt++;
    end
  end

  function automatic req_t random_req();
    req_t q;
    q.mode = 2'($urandom_range(0, 3));
    q.deadline = {$urandom, $urandom};
    q.user_token = {$urandom, $urandom};
    q.handle_slot_code = 9'($urandom);
    q.handle_generation = 16'($urandom);
    q.now_time = {$urandom, $urandom};
    return q;
  endfunction

  task automatic send(logic [1:0] mode, logic [63:0] dl, logic [63:0] tok,
                      logic [8:0] code, logic [15:0] gen, logic [63:0] now_t);
    req_t q;
    q = random_req();
    q.mode = mode;
    if (mode == MODE_SCHEDULE) begin
      q.deadline = dl;
      q.user_token = tok;
    end
    if (mode == MODE_CANCEL) begin
      q.handle_slot_code = code;
      q.handle_generation = gen;
    end
    if (mode == MODE_TAKE) q.now_time = now_t;
    pending_reqs.push_back(q);
    gen_cnt++;
  endtask

  // Build one random request against the model state as of now
  task automatic random_item(int sched_pct, int take_pct);
    req_t q;
    int roll;
    int s;
    int tries;
    q = random_req();
    roll = $urandom_range(0, 99);
    if (roll < sched_pct) begin
      q.mode = MODE_SCHEDULE;
      if ($urandom_range(0, 3) != 0) q.deadline = 64'($urandom_range(0, 2000));
    end else if (roll < sched_pct + take_pct) begin
      q.mode = MODE_TAKE;
      s = earliest_slot();
      case ($urandom_range(0, 4))
        0: q.now_time = '1;
        1: if (s >= 0) q.now_time = m_deadline[s];
        2: if (s >= 0) q.now_time = m_deadline[s] - 64'd1;
        3: q.now_time = 64'($urandom_range(0, 2000));
        default: ;
      endcase
    end else if (roll < sched_pct + take_pct + 10) begin
      q.mode = MODE_PEEK;
    end else begin
      q.mode = MODE_CANCEL;
      s = -1;
      for (tries = 0; tries < 16 && m_queued > 0; tries++) begin
        s = $urandom_range(0, NSLOT - 1);
        if (m_active[s]) break;
        s = -1;
      end
      if (s >= 0 && $urandom_range(0, 9) < 7) begin
        q.handle_slot_code = 9'(s + 1);
        q.handle_generation = m_gen[s];
        if ($urandom_range(0, 5) == 0) q.handle_generation = m_gen[s] - 16'd1;
      end
    end
    pending_reqs.push_back(q);
    gen_cnt++;
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    model_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(MODE_PEEK, 0, 0, 0, 0, 0);
    send(MODE_TAKE, 0, 0, 0, 0, '1);
    send(MODE_CANCEL, 0, 0, 9'd0, 16'd1, 0);
    send(MODE_CANCEL, 0, 0, 9'd1, 16'd0, 0);
    send(MODE_CANCEL, 0, 0, 9'h1FF, 16'd1, 0);
    send(MODE_CANCEL, 0, 0, 9'd1, 16'd1, 0);
    send(MODE_SCHEDULE, '1, '1, 0, 0, 0);
    send(MODE_SCHEDULE, 64'd0, 64'd0, 0, 0, 0);
    send(MODE_SCHEDULE, 64'd100, 64'hA5A5_5A5A_0F0F_F0F0, 0, 0, 0);
    send(MODE_SCHEDULE, 64'd100, 64'h1234_5678_9ABC_DEF0, 0, 0, 0);
    send(MODE_PEEK, 0, 0, 0, 0, 0);
    send(MODE_TAKE, 0, 0, 0, 0, 64'd0);
    send(MODE_TAKE, 0, 0, 0, 0, 64'd50);
    send(MODE_CANCEL, 0, 0, 9'd2, 16'd1, 0);
    send(MODE_CANCEL, 0, 0, 9'd3, 16'd1, 0);
    send(MODE_SCHEDULE, 64'd100, 64'd7, 0, 0, 0);
    send(MODE_TAKE, 0, 0, 0, 0, 64'd100);
    send(MODE_TAKE, 0, 0, 0, 0, '1);
    send(MODE_TAKE, 0, 0, 0, 0, '1);
    send(MODE_TAKE, 0, 0, 0, 0, '1);
    send(MODE_CANCEL, 0, 0, 9'd256, 16'd1, 0);
    send(MODE_CANCEL, 0, 0, 9'd257, 16'd1, 0);
    wait (pending_reqs.size() == 0 && issued_cnt == accepted_cnt);

    while (gen_cnt < N_ITEMS) begin
      idle_mode = (gen_cnt < 650) ? 0 : (gen_cnt < 1300) ? 1 : 2;
      if (gen_cnt >= 600 && gen_cnt < 616) rx_hold = 400;
      if (gen_cnt >= 1400 && gen_cnt < 1416)
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 &&
              issued_cnt == accepted_cnt);
      // Fill past capacity, then drain, elsewhere a balanced mix
      for (int i = 0; i < 16; i++) begin
        if (gen_cnt >= 600 && gen_cnt < 900) random_item(85, 5);
        else if (gen_cnt >= 900 && gen_cnt < 1150) random_item(5, 70);
        else random_item(35, 25);
      end
      wait (pending_reqs.size() == 0 && issued_cnt == accepted_cnt);
    end

    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d requests, peak occupancy %0d, %0d mismatches", accepted_cnt,
             peak_queued, mismatches);
    $display("Status counts ok %0d full %0d notfound %0d bad %0d empty %0d", status_seen[0],
             status_seen[1], status_seen[3], status_seen[4], status_seen[5]);
    if (mismatches == 0 && expected_rsps.size() == 0 && rsp_cnt == accepted_cnt)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("TIMEOUT with %0d responses outstanding", expected_rsps.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

### deadline_min_heap_queue_unit.f
rtl/dmhq_pkg.sv
rtl/dmhq_if.sv
rtl/dmhq_cell.sv
rtl/deadline_min_heap_queue_unit.sv
rtl/dmhq_checker.sv
dv/tb_top.sv
